FILE: rtl/cme_pkg.sv
// shared constants and types of the covariance matrix engine
// no dependencies
package cme_pkg;

  localparam int DEF_MAX_ROWS    = 256;
  localparam int DEF_MAX_DIMS    = 8;
  localparam int DEF_QUEUE_DEPTH = 2;

  localparam int SAMPLE_W  = 16;
  localparam int COV_W     = 41;
  localparam int DIM_IDX_W = 3;
  localparam int ROW_REG_W = 9;
  localparam int DIM_REG_W = 4;
  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W  = 1;

  localparam int JOB_ROW_W = 13;
  localparam int JOB_DIM_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_COUNT = 1'b1;

  typedef struct packed {
    logic [JOB_ROW_W-1:0] rows;
    logic [JOB_DIM_W-1:0] dims;
  } job_t;

endpackage

FILE: rtl/cme_if.sv
// item channels of the covariance matrix engine
// depends on cme_pkg
interface cme_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [cme_pkg::SAMPLE_W-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface cme_out_if;
  logic                                 valid;
  logic                                 ready;
  logic        [cme_pkg::DIM_IDX_W-1:0] row_dim;
  logic        [cme_pkg::DIM_IDX_W-1:0] col_dim;
  logic signed [cme_pkg::COV_W-1:0]     covariance;
  logic                                 last_entry;
  modport source (output valid, output row_dim, output col_dim, output covariance,
                  output last_entry, input ready);
  modport sink (input valid, input row_dim, input col_dim, input covariance,
                input last_entry, output ready);
endinterface

FILE: rtl/covariance_matrix_engine.sv
// load: one sample item per cycle; the item that completes an m-by-K matrix starts compute
// compute: column means, then covariance entries, on the single mac and the shared
// bit-serial divider (ACC_W = 34 + log2 MAX_ROWS)
// no sample is taken while a matrix is in compute; entries leave through an output register
// synchronous reset clears control and configuration (row_count = 1, dim_count = 1)
module covariance_matrix_engine #(
  parameter int MAX_ROWS    = cme_pkg::DEF_MAX_ROWS,
  parameter int MAX_DIMS    = cme_pkg::DEF_MAX_DIMS,
  parameter int QUEUE_DEPTH = cme_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  cme_in_if.sink                         in_ch,
  cme_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [cme_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cme_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int DEPTH = MAX_ROWS * MAX_DIMS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cme_pkg::job_t                job_in;
  cme_pkg::job_t                job_out;
  logic                         job_push;
  logic                         job_full;
  logic                         job_empty;
  logic                         job_pop;
  logic                         job_done;
  logic                         st_we;
  logic [AW-1:0]                st_waddr;
  logic [cme_pkg::SAMPLE_W-1:0] st_wdata;
  logic [AW-1:0]                raddr_a;
  logic [AW-1:0]                raddr_b;
  logic [cme_pkg::SAMPLE_W-1:0] rdata_a;
  logic [cme_pkg::SAMPLE_W-1:0] rdata_b;

  cme_front #(.MAX_ROWS(MAX_ROWS), .MAX_DIMS(MAX_DIMS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .job_done  (job_done),
    .job       (job_in),
    .job_push  (job_push),
    .job_full  (job_full),
    .st_we     (st_we),
    .st_waddr  (st_waddr),
    .st_wdata  (st_wdata)
  );

  cme_queue #(.payload_t(cme_pkg::job_t), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (job_push),
    .push_data (job_in),
    .full      (job_full),
    .pop       (job_pop),
    .pop_data  (job_out),
    .empty     (job_empty)
  );

  cme_ram #(.WIDTH(cme_pkg::SAMPLE_W), .DEPTH(DEPTH)) u_store_a (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  cme_ram #(.WIDTH(cme_pkg::SAMPLE_W), .DEPTH(DEPTH)) u_store_b (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  cme_back #(.MAX_ROWS(MAX_ROWS), .MAX_DIMS(MAX_DIMS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (job_out),
    .job_valid (!job_empty),
    .job_pop   (job_pop),
    .job_done  (job_done),
    .raddr_a   (raddr_a),
    .raddr_b   (raddr_b),
    .rdata_a   (rdata_a),
    .rdata_b   (rdata_b),
    .out_ch    (out_ch)
  );

endmodule

FILE: rtl/cme_ram.sv
// generic single write port ram with registered read
// no dependencies
module cme_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/cme_queue.sv
// short job queue between loader and compute sequencer
// no dependencies
module cme_queue #(
  parameter type payload_t = logic,
  parameter int  DEPTH = 2
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  payload_t push_data,
  output logic     full,
  input  logic     pop,
  output payload_t pop_data,
  output logic     empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  payload_t       slots [DEPTH];
  logic [PW-1:0]  wptr;
  logic [PW-1:0]  rptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : PW'(wptr + 1'b1);
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : PW'(rptr + 1'b1);
      end
      if (do_push && !do_pop) begin
        count <= CW'(count + 1'b1);
      end else if (do_pop && !do_push) begin
        count <= CW'(count - 1'b1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full) else $error("job queue overflow");

endmodule

FILE: rtl/cme_front.sv
// loader: configuration registers, sample store writes, job issue
// depends on cme_pkg and cme_if
module cme_front #(
  parameter int MAX_ROWS = cme_pkg::DEF_MAX_ROWS,
  parameter int MAX_DIMS = cme_pkg::DEF_MAX_DIMS,
  localparam int DEPTH = MAX_ROWS * MAX_DIMS,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                            clk,
  input  logic                            rst,
  cme_in_if.sink                          in_ch,
  input  logic                            cfg_we,
  input  logic [cme_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cme_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            job_done,
  output cme_pkg::job_t                   job,
  output logic                            job_push,
  input  logic                            job_full,
  output logic                            st_we,
  output logic [AW-1:0]                   st_waddr,
  output logic [cme_pkg::SAMPLE_W-1:0]    st_wdata
);

  localparam int ROW_W = $clog2(MAX_ROWS + 1);
  localparam int DIM_W = $clog2(MAX_DIMS + 1);
  localparam int TOT_W = AW + 1;

  logic [cme_pkg::ROW_REG_W-1:0] row_count;
  logic [cme_pkg::DIM_REG_W-1:0] dim_count;
  logic [TOT_W-1:0]              load_count;
  logic                          busy;
  logic [ROW_W-1:0]              eff_rows;
  logic [DIM_W-1:0]              eff_dims;
  logic [TOT_W-1:0]              total;
  logic                          accept;
  logic                          last_sample;

  always_comb begin
    if (row_count == '0) begin
      eff_rows = ROW_W'(1);
    end else if (32'(row_count) > 32'(MAX_ROWS)) begin
      eff_rows = ROW_W'(MAX_ROWS);
    end else begin
      eff_rows = ROW_W'(row_count);
    end
    if (dim_count == '0) begin
      eff_dims = DIM_W'(1);
    end else if (32'(dim_count) > 32'(MAX_DIMS)) begin
      eff_dims = DIM_W'(MAX_DIMS);
    end else begin
      eff_dims = DIM_W'(dim_count);
    end
  end

  assign total       = TOT_W'(TOT_W'(eff_rows) * TOT_W'(eff_dims));
  assign in_ch.ready = !busy && !job_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign last_sample = (load_count == TOT_W'(total - 1'b1));

  assign st_we    = accept;
  assign st_waddr = load_count[AW-1:0];
  assign st_wdata = in_ch.sample;

  assign job_push = accept && last_sample;
  assign job.rows = cme_pkg::JOB_ROW_W'(eff_rows);
  assign job.dims = cme_pkg::JOB_DIM_W'(eff_dims);

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count  <= cme_pkg::ROW_REG_W'(1);
      dim_count  <= cme_pkg::DIM_REG_W'(1);
      load_count <= '0;
      busy       <= 1'b0;
    end else begin
      if (job_done) begin
        busy <= 1'b0;
      end else if (accept && last_sample) begin
        busy <= 1'b1;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          cme_pkg::REG_ROW_COUNT: row_count <= cfg_data[cme_pkg::ROW_REG_W-1:0];
          cme_pkg::REG_DIM_COUNT: dim_count <= cfg_data[cme_pkg::DIM_REG_W-1:0];
          default: ;
        endcase
        load_count <= '0;
      end else if (accept) begin
        load_count <= last_sample ? '0 : TOT_W'(load_count + 1'b1);
      end
    end
  end

  a_wrap: assert property (@(posedge clk) disable iff (rst)
    (accept && last_sample && !cfg_we) |=> (load_count == '0) && busy)
    else $error("load count did not wrap on last sample");

endmodule

FILE: rtl/cme_div.sv
// shared radix-2 signed by unsigned divider, truncates toward zero
// no dependencies
module cme_div #(
  parameter int NUM_W = 42,
  parameter int DEN_W = 9
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] dividend,
  input  logic        [DEN_W-1:0] divisor,
  output logic                    done,
  output logic signed [NUM_W-1:0] quotient
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] mag;
  logic [DEN_W-1:0] rem;
  logic [CW-1:0]    cnt;
  logic             neg;
  logic             busy;
  logic [DEN_W:0]   rem_sh;
  logic             ge;

  assign rem_sh   = {rem, mag[NUM_W-1]};
  assign ge       = (rem_sh >= {1'b0, divisor});
  assign quotient = neg ? -$signed(mag) : $signed(mag);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        mag  <= dividend[NUM_W-1] ? NUM_W'(-dividend) : dividend;
        rem  <= '0;
        neg  <= dividend[NUM_W-1];
        cnt  <= CW'(NUM_W);
        busy <= 1'b1;
      end else if (busy) begin
        rem  <= ge ? DEN_W'(rem_sh - {1'b0, divisor}) : DEN_W'(rem_sh);
        mag  <= {mag[NUM_W-2:0], ge};
        cnt  <= CW'(cnt - 1'b1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/cme_back.sv
// compute sequencer: column means, then covariance entries on one mac
// depends on cme_pkg, cme_if, cme_ram and cme_div
module cme_back #(
  parameter int MAX_ROWS = cme_pkg::DEF_MAX_ROWS,
  parameter int MAX_DIMS = cme_pkg::DEF_MAX_DIMS,
  localparam int DEPTH = MAX_ROWS * MAX_DIMS,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cme_pkg::job_t                 job,
  input  logic                          job_valid,
  output logic                          job_pop,
  output logic                          job_done,
  output logic [AW-1:0]                 raddr_a,
  output logic [AW-1:0]                 raddr_b,
  input  logic [cme_pkg::SAMPLE_W-1:0]  rdata_a,
  input  logic [cme_pkg::SAMPLE_W-1:0]  rdata_b,
  cme_out_if.source                     out_ch
);

  localparam int SW    = cme_pkg::SAMPLE_W;
  localparam int ROW_W = $clog2(MAX_ROWS + 1);
  localparam int DIM_W = $clog2(MAX_DIMS + 1);
  localparam int KI_W  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int DW    = SW + 1;
  localparam int PW    = 2 * DW;
  localparam int ACC_W = PW + $clog2(MAX_ROWS);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_MSUM   = 11'b00000000010,
    S_MWAIT  = 11'b00000000100,
    S_MDIVGO = 11'b00000001000,
    S_MDIV   = 11'b00000010000,
    S_CSET   = 11'b00000100000,
    S_CSUM   = 11'b00001000000,
    S_CWAIT  = 11'b00010000000,
    S_CDIVGO = 11'b00100000000,
    S_CDIV   = 11'b01000000000,
    S_EMIT   = 11'b10000000000
  } state_t;

  state_t                  state;
  logic [ROW_W-1:0]        rows;
  logic [DIM_W-1:0]        dims;
  logic [KI_W-1:0]         k1;
  logic [KI_W-1:0]         k2;
  logic [ROW_W-1:0]        row_idx;
  logic [AW-1:0]           base1;
  logic [AW-1:0]           base2;
  logic signed [ACC_W-1:0] acc;
  logic                    p1;
  logic                    p2;
  logic                    p3;
  logic signed [DW-1:0]    d1;
  logic signed [DW-1:0]    d2;
  logic signed [PW-1:0]    prod;
  logic [SW-1:0]           mean_a;
  logic [SW-1:0]           mean_b;
  logic                    mean_we;
  logic                    div_start;
  logic                    div_done;
  logic signed [ACC_W-1:0] div_q;
  logic                    issue;
  logic                    last_row;
  logic                    last_dim1;
  logic                    last_dim2;
  logic                    emit_load;
  logic                    out_valid;

  assign issue     = (state == S_MSUM) || (state == S_CSUM);
  assign last_row  = (row_idx == ROW_W'(rows - 1'b1));
  assign last_dim1 = (k1 == KI_W'(dims - 1'b1));
  assign last_dim2 = (k2 == KI_W'(dims - 1'b1));
  assign raddr_a   = base1;
  assign raddr_b   = base2;
  assign job_pop   = (state == S_IDLE) && job_valid;
  assign mean_we   = (state == S_MDIV) && div_done;
  assign div_start = (state == S_MDIVGO) || (state == S_CDIVGO);
  assign emit_load = (state == S_EMIT) && (!out_valid || out_ch.ready);
  assign job_done  = emit_load && last_dim1 && last_dim2;
  assign out_ch.valid = out_valid;

  cme_ram #(.WIDTH(SW), .DEPTH(MAX_DIMS)) u_mean_a (
    .clk   (clk),
    .we    (mean_we),
    .waddr (k1),
    .wdata (div_q[SW-1:0]),
    .raddr (k1),
    .rdata (mean_a)
  );

  cme_ram #(.WIDTH(SW), .DEPTH(MAX_DIMS)) u_mean_b (
    .clk   (clk),
    .we    (mean_we),
    .waddr (k1),
    .wdata (div_q[SW-1:0]),
    .raddr (k2),
    .rdata (mean_b)
  );

  cme_div #(.NUM_W(ACC_W), .DEN_W(ROW_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc),
    .divisor  (rows),
    .done     (div_done),
    .quotient (div_q)
  );

  // mac datapath
  always_ff @(posedge clk) begin
    d1   <= $signed({rdata_a[SW-1], rdata_a}) - $signed({mean_a[SW-1], mean_a});
    d2   <= $signed({rdata_b[SW-1], rdata_b}) - $signed({mean_b[SW-1], mean_b});
    prod <= d1 * d2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
    if (emit_load) begin
      out_ch.row_dim    <= cme_pkg::DIM_IDX_W'(k1);
      out_ch.col_dim    <= cme_pkg::DIM_IDX_W'(k2);
      out_ch.covariance <= div_q[cme_pkg::COV_W-1:0];
      out_ch.last_entry <= last_dim1 && last_dim2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      p1    <= 1'b0;
      p2    <= 1'b0;
      p3    <= 1'b0;
    end else begin
      p1 <= issue;
      p2 <= p1 && ((state == S_CSUM) || (state == S_CWAIT));
      p3 <= p2;
      if (p1 && ((state == S_MSUM) || (state == S_MWAIT))) begin
        acc <= acc + ACC_W'($signed(rdata_a));
      end
      if (p3) begin
        acc <= acc + ACC_W'(prod);
      end
      if (issue) begin
        row_idx <= ROW_W'(row_idx + 1'b1);
        base1   <= AW'(base1 + AW'(dims));
        base2   <= AW'(base2 + AW'(dims));
      end
      unique case (state)
        S_IDLE: begin
          if (job_valid) begin
            rows    <= ROW_W'(job.rows);
            dims    <= DIM_W'(job.dims);
            k1      <= '0;
            k2      <= '0;
            row_idx <= '0;
            base1   <= '0;
            acc     <= '0;
            state   <= S_MSUM;
          end
        end
        S_MSUM: begin
          if (last_row) begin
            state <= S_MWAIT;
          end
        end
        S_MWAIT: begin
          if (!p1) begin
            state <= S_MDIVGO;
          end
        end
        S_MDIVGO: state <= S_MDIV;
        S_MDIV: begin
          if (div_done) begin
            if (last_dim1) begin
              k1    <= '0;
              k2    <= '0;
              state <= S_CSET;
            end else begin
              k1      <= KI_W'(k1 + 1'b1);
              row_idx <= '0;
              base1   <= AW'(k1 + 1'b1);
              acc     <= '0;
              state   <= S_MSUM;
            end
          end
        end
        S_CSET: begin
          row_idx <= '0;
          base1   <= AW'(k1);
          base2   <= AW'(k2);
          acc     <= '0;
          state   <= S_CSUM;
        end
        S_CSUM: begin
          if (last_row) begin
            state <= S_CWAIT;
          end
        end
        S_CWAIT: begin
          if (!p1 && !p2 && !p3) begin
            state <= S_CDIVGO;
          end
        end
        S_CDIVGO: state <= S_CDIV;
        S_CDIV: begin
          if (div_done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_load) begin
            if (last_dim1 && last_dim2) begin
              state <= S_IDLE;
            end else begin
              if (last_dim2) begin
                k1 <= KI_W'(k1 + 1'b1);
                k2 <= '0;
              end else begin
                k2 <= KI_W'(k2 + 1'b1);
              end
              state <= S_CSET;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    emit_load |=> out_valid) else $error("loaded item not presented");

  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_MDIV || state == S_CDIV))
    else $error("divider finished outside a divide state");

  a_mac_drained: assert property (@(posedge clk) disable iff (rst)
    div_start |-> (!p1 && !p2 && !p3)) else $error("divide started with mac busy");

endmodule
